@@ sv/fta_pkg.sv @@
// Shared types, constants and status codes of the frame table allocator.
package fta_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int PID_WIDTH   = 16;

  // Widths of the request and response fields.
  localparam int KIND_W   = 1;
  localparam int PID_IN_W = 16;
  localparam int COUNT_IN_W = 11;
  localparam int PAGE_IN_W  = 11;
  localparam int STATUS_W   = 2;
  localparam int FRAME_OUT_W = 10;

  localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
  localparam int ACC_W   = (CNT_W > COUNT_IN_W) ? CNT_W : COUNT_IN_W;

  localparam logic [KIND_W-1:0] KIND_ADMIT     = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TRANSLATE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADMITTED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DENIED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRANSLATED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAULT      = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [PID_WIDTH-1:0] pid;
  } owner_t;

  // Commands to the shared counter and compare unit.
  typedef struct packed {
    logic clr;
    logic inc;
  } acc_ctrl_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } acc_flags_t;

endpackage

@@ sv/fta_if.sv @@
// Request and response channel interfaces of the frame table allocator.
interface fta_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [fta_pkg::KIND_W-1:0]           kind;
  logic [fta_pkg::PID_IN_W-1:0]         pid;
  logic [fta_pkg::COUNT_IN_W-1:0]       page_count;
  logic signed [fta_pkg::PAGE_IN_W-1:0] page_no;

  modport source (output valid, kind, pid, page_count, page_no, input ready);
  modport sink   (input valid, kind, pid, page_count, page_no, output ready);
endinterface

interface fta_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fta_pkg::STATUS_W-1:0]    status;
  logic [fta_pkg::FRAME_OUT_W-1:0] frame;

  modport source (output valid, status, frame, input ready);
  modport sink   (input valid, status, frame, output ready);
endinterface

@@ sv/fta_scan_unit.sv @@
// Shared counter and comparator used by the request passes over the owner table.
module fta_scan_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  fta_pkg::acc_ctrl_t         ctrl,
  input  logic [fta_pkg::ACC_W-1:0]  target,
  output logic [fta_pkg::ACC_W-1:0]  acc,
  output fta_pkg::acc_flags_t        flags
);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.inc) begin
      acc <= acc + fta_pkg::ACC_W'(1);
    end
  end

  assign flags.eq = (acc == target);
  assign flags.lt = (acc < target);

endmodule

@@ sv/frame_table_allocator.sv @@
// Top level of the frame table allocator: owner table, sequencer and response register.
//
// The block keeps one owner entry per physical frame in an internal table
// with one read and one write port, and every request walks that table one
// entry per cycle. An admit takes two passes (count the free frames, then
// hand out the lowest ones), or one pass and a decision when it is denied.
// A translate takes one pass that stops at the matching frame, and on a fault
// a second pass that frees the pid's frames; a negative page skips straight
// to the freeing pass. After reset the table is cleared in a pass during
// which no request is accepted. One request is worked on at a time; a
// finished response waits in its own register, so the next request may be
// taken before it is collected.
module frame_table_allocator (
  input  logic      clk,
  input  logic      rst,
  fta_req_if.sink   req,
  fta_rsp_if.source rsp
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PASS1 = 3'd2;
  localparam logic [2:0] S_PASS2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [fta_pkg::IDX_W-1:0] LAST_IDX =
    fta_pkg::IDX_W'(fta_pkg::FRAME_COUNT - 1);

  logic [2:0] state;

  // Owner table.
  fta_pkg::owner_t mem [fta_pkg::FRAME_COUNT];
  fta_pkg::owner_t rdata;
  logic                      rd_en;
  logic                      wr_en;
  logic [fta_pkg::IDX_W-1:0] wr_addr;
  fta_pkg::owner_t           wr_data;

  // Scan position and read pipeline.
  logic [fta_pkg::IDX_W-1:0] idx;
  logic                      issued_all;
  logic                      rd_pending;
  logic [fta_pkg::IDX_W-1:0] q_idx;

  // Request held for the duration of the work.
  logic [fta_pkg::KIND_W-1:0]    kind_q;
  logic [fta_pkg::PID_WIDTH-1:0] pid_q;
  logic [fta_pkg::ACC_W-1:0]     target;

  logic [fta_pkg::STATUS_W-1:0]    res_status;
  logic [fta_pkg::FRAME_OUT_W-1:0] res_frame;
  logic                            rsp_valid;
  logic [fta_pkg::STATUS_W-1:0]    rsp_status;
  logic [fta_pkg::FRAME_OUT_W-1:0] rsp_frame;

  fta_pkg::acc_ctrl_t        ctrl;
  fta_pkg::acc_flags_t       flags;
  logic [fta_pkg::ACC_W-1:0] acc;

  logic accept;
  logic entry_free;
  logic entry_match;
  logic last;
  logic found;
  logic rsp_free;

  fta_scan_unit u_scan (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .target (target),
    .acc    (acc),
    .flags  (flags)
  );

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.frame  = rsp_frame;
  assign rsp_free   = !rsp_valid || rsp.ready;

  assign entry_free  = rd_pending && !rdata.valid;
  assign entry_match = rd_pending && rdata.valid && (rdata.pid == pid_q);
  assign last        = rd_pending && (q_idx == LAST_IDX);
  assign found       = (state == S_PASS1) && (kind_q == fta_pkg::KIND_TRANSLATE) &&
                       entry_match && flags.eq;

  assign rd_en = ((state == S_PASS1) || (state == S_PASS2)) && !issued_all && !found;

  always_comb begin
    ctrl    = '0;
    wr_en   = 1'b0;
    wr_addr = q_idx;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx;
      end
      S_IDLE: begin
        ctrl.clr = accept;
      end
      S_PASS1: begin
        if (kind_q == fta_pkg::KIND_ADMIT) begin
          ctrl.inc = entry_free;
        end else begin
          ctrl.inc = entry_match && !flags.eq;
        end
      end
      S_PASS2: begin
        // The second pass counts from zero again, once the free count has been judged.
        if (!rd_pending) begin
          ctrl.clr = 1'b1;
        end
        if (kind_q == fta_pkg::KIND_ADMIT) begin
          if (entry_free && !flags.eq) begin
            ctrl.inc    = 1'b1;
            wr_en       = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.pid   = pid_q;
          end
        end else begin
          wr_en = entry_match;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[idx];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      issued_all <= 1'b0;
      rd_pending <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (rd_en) begin
        idx <= idx + fta_pkg::IDX_W'(1);
        if (idx == LAST_IDX) begin
          issued_all <= 1'b1;
        end
      end
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + fta_pkg::IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            idx        <= '0;
            issued_all <= 1'b0;
            kind_q     <= req.kind;
            pid_q      <= fta_pkg::PID_WIDTH'(req.pid);
            res_frame  <= '0;
            if (req.kind == fta_pkg::KIND_ADMIT) begin
              target     <= fta_pkg::ACC_W'(req.page_count);
              res_status <= fta_pkg::ST_ADMITTED;
              state      <= S_PASS1;
            end else begin
              target     <= fta_pkg::ACC_W'(req.page_no[fta_pkg::PAGE_IN_W-2:0]);
              res_status <= fta_pkg::ST_FAULT;
              // A negative page faults without any search.
              state <= req.page_no[fta_pkg::PAGE_IN_W-1] ? S_PASS2 : S_PASS1;
            end
          end
        end
        S_PASS1: begin
          if (found) begin
            res_status <= fta_pkg::ST_TRANSLATED;
            res_frame  <= fta_pkg::FRAME_OUT_W'(q_idx);
            state      <= S_DONE;
          end else if (last) begin
            idx        <= '0;
            issued_all <= 1'b0;
            state      <= S_PASS2;
          end
        end
        S_PASS2: begin
          // The counter now holds every free frame, the last one included.
          if (!rd_pending && (kind_q == fta_pkg::KIND_ADMIT) && flags.lt) begin
            res_status <= fta_pkg::ST_DENIED;
            state      <= S_DONE;
          end else if (last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_frame  <= res_frame;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table is only written while it is being cleared or updated.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR) || (state == S_PASS2))
    else $error("owner table written outside a clearing or update pass");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request ready while the owner table is being cleared");

  a_no_stray_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_pending)
    else $error("table read still in flight while idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_PASS1) || (state == S_PASS2))
    else $error("accepted request did not start a pass");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc <= fta_pkg::ACC_W'(fta_pkg::FRAME_COUNT))
    else $error("scan counter beyond the frame count");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench of the frame table allocator against a table predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_REQS = 560;
  localparam int CALM_ITEMS  = 40;
  localparam int LIVE        = 0;
  localparam int PLAN        = 1;
  localparam int WORST_REQ   = 2 * fta_pkg::FRAME_COUNT + 20;
  localparam int LIMIT       = (RANDOM_REQS + 40) * WORST_REQ * 4 + 4 * fta_pkg::FRAME_COUNT;

  typedef struct packed {
    logic [fta_pkg::KIND_W-1:0]           kind;
    logic [fta_pkg::PID_IN_W-1:0]         pid;
    logic [fta_pkg::COUNT_IN_W-1:0]       page_count;
    logic signed [fta_pkg::PAGE_IN_W-1:0] page_no;
    logic                                 drain_first;
  } frame_req_t;

  typedef struct packed {
    logic [fta_pkg::STATUS_W-1:0]    status;
    logic [fta_pkg::FRAME_OUT_W-1:0] frame;
  } frame_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fta_req_if req_ch ();
  fta_rsp_if rsp_ch ();

  frame_table_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Two copies of the owner table: one follows the accepted beats, the other
  // is used while the stimulus is planned so that pages can be aimed at.
  fta_pkg::owner_t ledger [2][fta_pkg::FRAME_COUNT];

  frame_req_t pending_reqs[$];
  frame_rsp_t expected_rsps[$];
  int         owed        = 0;
  int         mismatches  = 0;
  int         send_gap    = 0;
  int         stall_left  = 0;
  int         mode_timer  = 0;
  int         cycle_count = 0;
  logic       draining    = 1'b0;
  logic       calm        = 1'b0;
  logic       noisy       = 1'b1;

  always #10 clk = ~clk;

  function automatic frame_rsp_t serve_request(input int side, input frame_req_t r);
    frame_rsp_t                    o;
    logic [fta_pkg::PID_WIDTH-1:0] who;
    int unsigned                   free_n;
    int unsigned                   given;
    int unsigned                   seen;
    logic                          hit;
    who      = r.pid[fta_pkg::PID_WIDTH-1:0];
    o.status = fta_pkg::ST_FAULT;
    o.frame  = '0;
    free_n   = 0;
    given    = 0;
    seen     = 0;
    hit      = 1'b0;
    if (r.kind == fta_pkg::KIND_ADMIT) begin
      for (int i = 0; i < fta_pkg::FRAME_COUNT; i++)
        if (!ledger[side][i].valid) free_n++;
      if (free_n < r.page_count) begin
        o.status = fta_pkg::ST_DENIED;
      end else begin
        o.status = fta_pkg::ST_ADMITTED;
        for (int i = 0; i < fta_pkg::FRAME_COUNT; i++) begin
          if (!ledger[side][i].valid && given < r.page_count) begin
            ledger[side][i] = '{valid: 1'b1, pid: who};
            given++;
          end
        end
      end
    end else begin
      if (!r.page_no[fta_pkg::PAGE_IN_W-1]) begin
        for (int i = 0; i < fta_pkg::FRAME_COUNT; i++) begin
          if (!hit && ledger[side][i].valid && ledger[side][i].pid == who) begin
            if (seen == int'(r.page_no)) begin
              o.status = fta_pkg::ST_TRANSLATED;
              o.frame  = fta_pkg::FRAME_OUT_W'(i);
              hit      = 1'b1;
            end else begin
              seen++;
            end
          end
        end
      end
      // A miss of any kind takes every frame away from the pid.
      if (!hit) begin
        for (int i = 0; i < fta_pkg::FRAME_COUNT; i++)
          if (ledger[side][i].valid && ledger[side][i].pid == who) ledger[side][i] = '0;
      end
    end
    return o;
  endfunction

  function automatic int pages_of(input int side, input logic [fta_pkg::PID_IN_W-1:0] pid);
    int n;
    n = 0;
    for (int i = 0; i < fta_pkg::FRAME_COUNT; i++)
      if (ledger[side][i].valid && ledger[side][i].pid == pid[fta_pkg::PID_WIDTH-1:0]) n++;
    return n;
  endfunction

  function automatic int free_of(input int side);
    int n;
    n = 0;
    for (int i = 0; i < fta_pkg::FRAME_COUNT; i++)
      if (!ledger[side][i].valid) n++;
    return n;
  endfunction

  task automatic queue_request(input logic [fta_pkg::KIND_W-1:0] kind,
                               input logic [fta_pkg::PID_IN_W-1:0] pid,
                               input int count, input int page, input logic drain);
    frame_req_t r;
    r.kind        = kind;
    r.pid         = pid;
    r.page_count  = count[fta_pkg::COUNT_IN_W-1:0];
    r.page_no     = page[fta_pkg::PAGE_IN_W-1:0];
    r.drain_first = drain;
    void'(serve_request(PLAN, r));
    pending_reqs.push_back(r);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    logic [fta_pkg::PID_IN_W-1:0] pid_pool [8];
    logic [fta_pkg::PID_IN_W-1:0] pid;
    int                           roll;
    int                           owned;
    int                           count;
    for (int i = 0; i < fta_pkg::FRAME_COUNT; i++) ledger[PLAN][i] = '0;

    queue_request(fta_pkg::KIND_TRANSLATE, 16'h0000, 0, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h0000, 0, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'hFFFF, 1024, 0, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'hFFFF, 0, 1023, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'hFFFF, 0, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h0000, 1, 0, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'hFFFF, 2047, -1, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h5555, 1023, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'hAAAA, 2, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'hAAAA, 1, 0, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'hAAAA, 0, 0, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'hAAAA, 0, 1, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'h5555, 0, -1024, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h1234, 3, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h4321, 2, 0, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h1234, 2, 0, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'h1234, 0, 3, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'h4321, 0, 1, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'h1234, 0, 5, 1'b0);
    queue_request(fta_pkg::KIND_ADMIT, 16'h0F0F, 4, 0, 1'b1);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'h0F0F, 0, 3, 1'b0);
    queue_request(fta_pkg::KIND_TRANSLATE, 16'h4321, 0, 0, 1'b0);

    pid_pool[0] = 16'h0000;
    pid_pool[1] = 16'hFFFF;
    pid_pool[2] = 16'h5555;
    pid_pool[3] = 16'hAAAA;
    for (int i = 4; i < 8; i++) pid_pool[i] = fta_pkg::PID_IN_W'($urandom);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(0, 99);
      pid  = pid_pool[$urandom_range(0, 7)];
      if (roll < 40) begin
        if ($urandom_range(0, 9) == 0) pid = fta_pkg::PID_IN_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 70) count = $urandom_range(0, 24);
        else if (roll < 85) count = $urandom_range(0, 1024);
        else count = free_of(PLAN) + $urandom_range(0, 6);
        if (count > 1024) count = 1024;
        queue_request(fta_pkg::KIND_ADMIT, pid, count, $urandom,
                      $urandom_range(0, 49) == 0);
      end else if (roll < 85) begin
        // Aim at a page that exists, preferring a pid that holds frames.
        for (int k = 0; k < 8 && pages_of(PLAN, pid) == 0; k++)
          pid = pid_pool[$urandom_range(0, 7)];
        owned = pages_of(PLAN, pid);
        queue_request(fta_pkg::KIND_TRANSLATE, pid, $urandom,
                      (owned > 0) ? $urandom_range(0, owned - 1) : $urandom_range(0, 3),
                      $urandom_range(0, 49) == 0);
      end else begin
        roll = $urandom_range(0, 2);
        if (roll == 0) begin
          queue_request(fta_pkg::KIND_TRANSLATE, pid, $urandom,
                        -int'($urandom_range(1, 1024)), 1'b0);
        end else if (roll == 1) begin
          queue_request(fta_pkg::KIND_TRANSLATE, pid, $urandom,
                        pages_of(PLAN, pid) + $urandom_range(0, 3), 1'b0);
        end else begin
          queue_request(fta_pkg::KIND_TRANSLATE, fta_pkg::PID_IN_W'($urandom), $urandom,
                        $urandom_range(0, 2047) - 1024, 1'b0);
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_ch.valid || owed != 0) @(negedge clk);
    repeat (WORST_REQ) @(negedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Request driver.
  always @(posedge clk) begin : driver
    frame_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      calm <= (pending_reqs.size() < CALM_ITEMS);
      if (send_gap != 0) begin
        req_ch.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (pending_reqs[0].drain_first && (!draining || owed != 0)) begin
        // Hold back until every outstanding response has been collected.
        req_ch.valid <= 1'b0;
        draining     <= 1'b1;
      end else begin
        nxt                = pending_reqs.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= nxt.kind;
        req_ch.pid         <= nxt.pid;
        req_ch.page_count  <= nxt.page_count;
        req_ch.page_no     <= nxt.page_no;
        draining           <= 1'b0;
        if (!calm && $urandom_range(0, 2) == 0) send_gap <= $urandom_range(1, 5);
      end
    end
  end

  // Response back-pressure, in bursts, with quiet stretches in between.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!calm && noisy && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 4);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      if (mode_timer == 0) begin
        noisy      <= ($urandom_range(0, 3) != 0);
        mode_timer <= $urandom_range(200, 3000);
      end else begin
        mode_timer <= mode_timer - 1;
      end
    end
  end

  // Monitor: predicts on every accepted request beat and checks every response beat.
  always @(posedge clk) begin : monitor
    frame_req_t r;
    frame_rsp_t want;
    frame_rsp_t got;
    int         delta;
    if (rst) begin
      for (int i = 0; i < fta_pkg::FRAME_COUNT; i++) ledger[LIVE][i] = '0;
      owed <= 0;
    end else begin
      delta = 0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.frame  = rsp_ch.frame;
        delta--;
        if (expected_rsps.size() == 0) begin
          $display("%0t ns: response with none expected, actual status %0d frame %0d",
                   $time, got.status, got.frame);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatches++;
          end
          if (got.frame !== want.frame) begin
            $display("%0t ns: frame mismatch, expected %0d, actual %0d",
                     $time, want.frame, got.frame);
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        r.kind        = req_ch.kind;
        r.pid         = req_ch.pid;
        r.page_count  = req_ch.page_count;
        r.page_no     = req_ch.page_no;
        r.drain_first = 1'b0;
        expected_rsps.push_back(serve_request(LIVE, r));
        delta++;
      end
      owed <= owed + delta;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
